### rtl/core/fadd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fadd_pkg: shared types and constants for the fraction adder
// Field widths, cell control struct and sequencer states.
// ----------------------------------------------------------------------------
package fadd_pkg;

   localparam int NumW  = 16;
   localparam int DenW  = 15;
   localparam int SNumW = 32;
   localparam int SDenW = 30;
   localparam int MagW  = 31;   // magnitude of the unreduced numerator
   localparam int ProdW = 30;   // d1 * d2

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_GCD,
      ST_DIVN,
      ST_DIVD,
      ST_DONE
   } state_type;

   // Control handed to every cell of the divider row.
   typedef struct packed {
      logic load;   // start a new division
      logic step;   // shift one quotient bit through the row
   } cell_ctrl_type;

endpackage

### rtl/core/fadd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fadd_req_if / fadd_rsp_if: valid-ready channels
// Request carries two fractions, response the reduced sum.
// ----------------------------------------------------------------------------
interface fadd_req_if;
   logic                        valid;
   logic                        ready;
   logic signed [15:0]          first_numerator;
   logic        [14:0]          first_denominator;
   logic signed [15:0]          second_numerator;
   logic        [14:0]          second_denominator;
   modport source (output valid, first_numerator, first_denominator,
                   second_numerator, second_denominator, input ready);
   modport sink   (input valid, first_numerator, first_denominator,
                   second_numerator, second_denominator, output ready);
endinterface

interface fadd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic signed [31:0]          sum_numerator;
   logic        [29:0]          sum_denominator;
   modport source (output valid, sum_numerator, sum_denominator, input ready);
   modport sink   (input valid, sum_numerator, sum_denominator, output ready);
endinterface

### rtl/core/fadd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fadd_cell: one bit slice of the restoring divider row
// Holds one remainder bit and one dividend bit; takes the borrow from the
// lower neighbour and the shift-in bit from the lower neighbour.
// ----------------------------------------------------------------------------
module fadd_cell (
   input  logic                   clock,
   input  fadd_pkg::cell_ctrl_type ctrl,
   input  logic                   load_bit,   // dividend bit at load
   input  logic                   div_bit,    // divisor bit of this slice
   input  logic                   rem_lo,     // remainder bit shifted in from below
   input  logic                   quo_lo,     // dividend bit shifted in from below
   input  logic                   borrow_in,
   input  logic                   take,       // row-wide: subtraction fits
   output logic                   borrow_out,
   output logic                   rem_q,
   output logic                   quo_q
);
   import fadd_pkg::*;

   logic rem_ff, rem_in, quo_ff, quo_in, diff;

   // shifted remainder bit is the lower neighbour's remainder
   assign diff       = rem_lo ^ div_bit ^ borrow_in;
   assign borrow_out = (~rem_lo & (div_bit | borrow_in)) | (div_bit & borrow_in);

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (ctrl.load) begin
         rem_in = 1'b0;
         quo_in = load_bit;
      end else if (ctrl.step) begin
         rem_in = take ? diff : rem_lo;
         quo_in = quo_lo;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign rem_q = rem_ff;
   assign quo_q = quo_ff;
endmodule

### rtl/core/fadd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fadd_div: restoring divider built from a row of bit cells
// One quotient bit per step; remainder available after Width steps.
// ----------------------------------------------------------------------------
module fadd_div #(
   parameter int Width = 31
) (
   input  logic                    clock,
   input  fadd_pkg::cell_ctrl_type ctrl,
   input  logic [Width-1:0]        dividend,
   input  logic [Width-1:0]        divisor,
   output logic [Width-1:0]        quotient,
   output logic [Width-1:0]        remainder
);
   import fadd_pkg::*;

   logic [Width:0]   borrow;
   logic [Width-1:0] rem_q, quo_q, rem_lo, quo_lo;
   logic             take;

   assign borrow[0] = 1'b0;
   // top remainder bit falls out of the row on a shift; it still counts in
   // the compare, so the full Width+1 bit value is seen
   assign take = rem_q[Width-1] | ~borrow[Width];

   genvar i;
   generate
      for (i = 0; i < Width; i++) begin : g_cell
         if (i == 0) begin : g_lo
            assign rem_lo[i] = quo_q[Width-1];
            assign quo_lo[i] = take;
         end else begin : g_hi
            assign rem_lo[i] = rem_q[i-1];
            assign quo_lo[i] = quo_q[i-1];
         end
         fadd_cell u_cell (
            .clock     (clock),
            .ctrl      (ctrl),
            .load_bit  (dividend[i]),
            .div_bit   (divisor[i]),
            .rem_lo    (rem_lo[i]),
            .quo_lo    (quo_lo[i]),
            .borrow_in (borrow[i]),
            .take      (take),
            .borrow_out(borrow[i+1]),
            .rem_q     (rem_q[i]),
            .quo_q     (quo_q[i])
         );
      end
   endgenerate

   assign quotient  = quo_q;
   assign remainder = rem_q;
endmodule

### rtl/core/fraction_add_reduce.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction_add_reduce: add two fractions, reduce to lowest terms
// Cross-multiplies (or sums over a shared denominator), then Euclid's gcd
// and two exact divisions, all on one bit-cell divider row.
// ----------------------------------------------------------------------------
// Channel | Dir | Transfer when        | Payload
// req     | in  | req.valid&req.ready  | n1[16] d1[15] n2[16] d2[15]
// rsp     | out | rsp.valid&rsp.ready  | sum_numerator[32] sum_denominator[30]
//
// One item at a time. Every division is a load and 31 steps on the
// shared divider row; Euclid needs up to ~45 remainders for 31-bit
// values, and the numerator and denominator are then each divided by
// the gcd. A zero sum skips the row. Reset (synchronous) returns to
// idle and drops any pending result. The result register holds under
// rsp stall and is only loaded from DONE once free; req is ready only
// when idle.
// ----------------------------------------------------------------------------
module fraction_add_reduce (
   input  logic     clock,
   input  logic     reset,
   fadd_req_if.sink   req,
   fadd_rsp_if.source rsp
);
   import fadd_pkg::*;

   localparam int CntW = $clog2(MagW + 1);

   state_type        state_ff, state_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic             neg_ff, neg_in;
   logic [MagW-1:0]  mag_ff, mag_in;      // |numerator|
   logic [MagW-1:0]  den_ff, den_in;      // denominator, reduced once done
   logic [MagW-1:0]  ga_ff, ga_in, gb_ff, gb_in;  // Euclid pair
   logic [MagW-1:0]  qn_ff, qn_in;        // reduced magnitude
   logic [SNumW-1:0] onum_ff, onum_in;
   logic [SDenW-1:0] oden_ff, oden_in;
   logic             ovld_ff, ovld_in;

   // multiply stage
   logic signed [15:0] n1_ff, n2_ff;
   logic        [14:0] d1_ff, d2_ff;
   logic signed [31:0] p1, p2;
   logic signed [32:0] nsum;
   logic        [29:0] dprod;

   cell_ctrl_type     dctl;
   logic [MagW-1:0]   dvd, dvs, quo, rem;

   fadd_div #(.Width(MagW)) u_div (
      .clock    (clock),
      .ctrl     (dctl),
      .dividend (dvd),
      .divisor  (dvs),
      .quotient (quo),
      .remainder(rem)
   );

   assign req.ready         = (state_ff == ST_IDLE);
   assign rsp.valid         = ovld_ff;
   assign rsp.sum_numerator = onum_ff;
   assign rsp.sum_denominator = oden_ff;

   assign p1    = n1_ff * $signed({1'b0, d2_ff});
   assign p2    = n2_ff * $signed({1'b0, d1_ff});
   assign dprod = d1_ff * d2_ff;

   // Final step of the row evaluated for the value captured at the last edge
   function automatic logic [MagW:0] last_step(input logic [MagW-1:0] r,
                                               input logic [MagW-1:0] q);
      logic [MagW:0] sh;
      sh = {r, q[MagW-1]};
      return sh;
   endfunction

   function automatic logic [MagW-1:0] rem_next(input logic [MagW-1:0] r,
                                                input logic [MagW-1:0] q,
                                                input logic [MagW-1:0] d);
      logic [MagW:0] sh;
      sh = last_step(r, q);
      return (sh >= {1'b0, d}) ? MagW'(sh - {1'b0, d}) : MagW'(sh);
   endfunction

   function automatic logic [MagW-1:0] quo_next(input logic [MagW-1:0] r,
                                                input logic [MagW-1:0] q,
                                                input logic [MagW-1:0] d);
      logic [MagW:0] sh;
      sh = last_step(r, q);
      return {q[MagW-2:0], (sh >= {1'b0, d})};
   endfunction

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         n1_ff <= req.first_numerator;
         n2_ff <= req.second_numerator;
         d1_ff <= (req.first_denominator == '0) ? 15'd1 : req.first_denominator;
         d2_ff <= (req.second_denominator == '0) ? 15'd1 : req.second_denominator;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ovld_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ovld_ff  <= ovld_in;
         cnt_ff   <= cnt_in;
      end
      neg_ff  <= neg_in;
      mag_ff  <= mag_in;
      den_ff  <= den_in;
      ga_ff   <= ga_in;
      gb_ff   <= gb_in;
      qn_ff   <= qn_in;
      onum_ff <= onum_in;
      oden_ff <= oden_in;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      den_in   = den_ff;
      ga_in    = ga_ff;
      gb_in    = gb_ff;
      qn_in    = qn_ff;
      onum_in  = onum_ff;
      oden_in  = oden_ff;
      ovld_in  = ovld_ff & ~rsp.ready;
      dctl     = '0;
      dvd      = ga_ff;
      dvs      = gb_ff;
      nsum     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid) state_in = ST_MUL;
         end
         ST_MUL: begin
            if (d1_ff == d2_ff) begin
               nsum   = 33'(n1_ff) + 33'(n2_ff);
               den_in = MagW'(d1_ff);
            end else begin
               nsum   = 33'(p1) + 33'(p2);
               den_in = MagW'(dprod);
            end
            neg_in = nsum[32];
            mag_in = nsum[32] ? MagW'(-nsum) : MagW'(nsum);
            ga_in  = nsum[32] ? MagW'(-nsum) : MagW'(nsum);
            gb_in  = den_in;
            cnt_in = '0;
            if (nsum == '0) begin
               // zero sum: result is 0/1, staged until the output is free
               qn_in    = '0;
               den_in   = MagW'(1);
               state_in = ST_DONE;
            end else begin
               state_in = ST_GCD;
            end
         end
         ST_GCD: begin
            // one Euclid remainder per pass of the row
            if (cnt_ff == '0) begin
               if (gb_ff == '0) begin
                  dvd      = mag_ff;
                  dvs      = ga_ff;
                  dctl.load = 1'b1;
                  cnt_in   = CntW'(1);
                  state_in = ST_DIVN;
               end else begin
                  dctl.load = 1'b1;
                  cnt_in   = CntW'(1);
               end
            end else begin
               dctl.step = 1'b1;
               if (cnt_ff == CntW'(MagW)) begin
                  cnt_in = '0;
                  ga_in  = gb_ff;
                  gb_in  = rem_next(rem, quo, gb_ff);
               end else begin
                  cnt_in = cnt_ff + CntW'(1);
               end
            end
         end
         ST_DIVN: begin
            dvs       = ga_ff;
            dctl.step = 1'b1;
            if (cnt_ff == CntW'(MagW)) begin
               qn_in     = quo_next(rem, quo, ga_ff);
               dvd       = den_ff;
               cnt_in    = '0;
               state_in  = ST_DIVD;
            end else begin
               cnt_in = cnt_ff + CntW'(1);
            end
         end
         ST_DIVD: begin
            dvs = ga_ff;
            dvd = den_ff;
            if (cnt_ff == '0) begin
               dctl.load = 1'b1;
               cnt_in    = CntW'(1);
            end else begin
               dctl.step = 1'b1;
               if (cnt_ff == CntW'(MagW)) begin
                  den_in   = quo_next(rem, quo, ga_ff);
                  state_in = ST_DONE;
               end else begin
                  cnt_in = cnt_ff + CntW'(1);
               end
            end
         end
         ST_DONE: begin
            // result register only reloaded once the previous transfer is gone
            if (!ovld_ff || rsp.ready) begin
               ovld_in  = 1'b1;
               onum_in  = neg_ff ? -SNumW'(qn_ff) : SNumW'(qn_ff);
               oden_in  = SDenW'(den_ff);
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // result never left pending with an invalid denominator
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.sum_denominator != '0) else $error("zero denominator");
   // no new request while busy
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req.ready) else $error("accepted while busy");
   // result stays valid with its numerator unchanged while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid && $stable(rsp.sum_numerator))
      else $error("result dropped under stall");
endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for fraction_add_reduce
// Drives fraction pairs over the request channel, predicts each reduced sum
// with an independent Euclid model and compares every response transfer.
// ----------------------------------------------------------------------------
module tb_top;
   import fadd_pkg::*;

   typedef struct packed {
      logic signed [15:0] n1;
      logic        [14:0] d1;
      logic signed [15:0] n2;
      logic        [14:0] d2;
   } frac_pair_type;

   typedef struct packed {
      logic signed [31:0] num;
      logic        [29:0] den;
   } frac_sum_type;

   // Limit covers every item plus stalls; taken very generously.
   localparam int CycleLimit = 12_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fadd_req_if req ();
   fadd_rsp_if rsp ();

   fraction_add_reduce dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   always #5 clock = ~clock;

   frac_pair_type pending_pairs[$];
   frac_sum_type  expected_sums[$];
   int            errors = 0;
   int            sums_checked = 0;
   int            cycle_count = 0;
   int            zero_sums = 0;
   int            equal_dens = 0;
   int            transfers_in = 0;
   logic          req_taken = 1'b0;   // offered pair went across at last edge

   // Reduced sum of two fractions; zero denominators count as one.
   function automatic frac_sum_type reduce_sum(frac_pair_type p);
      longint       a_n, a_d, b_n, b_d, num, den, x, y, t;
      frac_sum_type r;
      a_n = p.n1;
      b_n = p.n2;
      a_d = (p.d1 == 0) ? 1 : p.d1;
      b_d = (p.d2 == 0) ? 1 : p.d2;
      if (a_d == b_d) begin
         num = a_n + b_n;
         den = a_d;
      end else begin
         num = a_n * b_d + b_n * a_d;
         den = a_d * b_d;
      end
      if (num == 0) begin
         num = 0;
         den = 1;
      end else begin
         x = (num < 0) ? -num : num;
         y = den;
         while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
         end
         num = num / x;
         den = den / x;
      end
      r.num = num[31:0];
      r.den = den[29:0];
      return r;
   endfunction

   function automatic frac_pair_type make_pair(logic signed [15:0] n1, logic [14:0] d1,
                                               logic signed [15:0] n2, logic [14:0] d2);
      frac_pair_type p;
      p.n1 = n1;
      p.d1 = d1;
      p.n2 = n2;
      p.d2 = d2;
      return p;
   endfunction

   // Random pair: mix of full range, small values, shared denominators, denominators 0 to 3.
   function automatic frac_pair_type random_pair();
      frac_pair_type p;
      int            mode;
      mode = int'($urandom_range(0, 9));
      p.n1 = 16'($urandom);
      p.n2 = 16'($urandom);
      p.d1 = 15'($urandom);
      p.d2 = 15'($urandom);
      case (mode)
         0, 1: begin
            p.d2 = p.d1;                       // shared denominator
         end
         2, 3: begin
            p.n1 = 16'(int'($urandom_range(0, 40)) - 20);
            p.n2 = 16'(int'($urandom_range(0, 40)) - 20);
            p.d1 = 15'($urandom_range(1, 24));
            p.d2 = 15'($urandom_range(1, 24));
         end
         4: begin
            p.n2 = -p.n1;                      // often a zero sum
            p.d2 = p.d1;
         end
         5: begin
            p.d1 = 15'($urandom_range(0, 3));
            p.d2 = 15'($urandom_range(0, 3));
         end
         default: begin
         end
      endcase
      return p;
   endfunction

   // Quiet stretch in the middle of the run; one drain hold-off.
   function automatic logic quiet_mode();
      return (transfers_in >= 600) && (transfers_in < 800);
   endfunction

   function automatic logic hold_off();
      return (transfers_in == 300) && (expected_sums.size() != 0);
   endfunction

   // Directed items, then the random body.
   initial begin
      frac_pair_type p;
      pending_pairs.push_back(make_pair(16'sh7FFF, 15'h7FFF, 16'sh7FFF, 15'h7FFE));
      pending_pairs.push_back(make_pair(-16'sh8000, 15'h7FFF, -16'sh8000, 15'h7FFE));
      pending_pairs.push_back(make_pair(-16'sh8000, 15'd1, -16'sh8000, 15'd1));
      pending_pairs.push_back(make_pair(16'sh7FFF, 15'd1, 16'sh7FFF, 15'd1));
      pending_pairs.push_back(make_pair(16'sd3, 15'd4, -16'sd3, 15'd4));
      pending_pairs.push_back(make_pair(16'sd1, 15'd2, -16'sd1, 15'd3));
      pending_pairs.push_back(make_pair(16'sd1, 15'd6, 16'sd1, 15'd3));
      pending_pairs.push_back(make_pair(16'sd0, 15'd5, 16'sd0, 15'd7));
      pending_pairs.push_back(make_pair(16'sd5, 15'd0, 16'sd2, 15'd0));
      pending_pairs.push_back(make_pair(16'sd5, 15'd0, 16'sd2, 15'd1));
      pending_pairs.push_back(make_pair(16'sd5, 15'd0, 16'sd2, 15'd3));
      pending_pairs.push_back(make_pair(-16'sd7, 15'd9, 16'sd4, 15'd6));
      pending_pairs.push_back(make_pair(16'sh5555, 15'h2AAA, -16'sh5556, 15'h5555));
      pending_pairs.push_back(make_pair(-16'sd1, 15'h7FFF, 16'sd1, 15'h7FFF));
      pending_pairs.push_back(make_pair(16'sh7FFF, 15'h7FFF, -16'sh8000, 15'h7FFE));
      pending_pairs.push_back(make_pair(16'sd6, 15'd10, 16'sd9, 15'd15));
      repeat (1640) begin
         p = random_pair();
         pending_pairs.push_back(p);
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   // Request driver: changes at the falling edge.
   always @(negedge clock) begin
      if (reset) begin
         req.valid              <= 1'b0;
         req.first_numerator    <= '0;
         req.first_denominator  <= '0;
         req.second_numerator   <= '0;
         req.second_denominator <= '0;
      end else if (req.valid && !req_taken) begin
         // hold the offered pair until the transfer
      end else if (pending_pairs.size() != 0 && !hold_off() &&
                   (quiet_mode() || $urandom_range(0, 99) >= 14)) begin
         req.valid              <= 1'b1;
         req.first_numerator    <= pending_pairs[0].n1;
         req.first_denominator  <= pending_pairs[0].d1;
         req.second_numerator   <= pending_pairs[0].n2;
         req.second_denominator <= pending_pairs[0].d2;
         void'(pending_pairs.pop_front());
      end else begin
         req.valid <= 1'b0;
      end
   end

   // Response back-pressure.
   always @(negedge clock) begin
      if (reset)
         rsp.ready <= 1'b0;
      else
         rsp.ready <= quiet_mode() || ($urandom_range(0, 99) >= 14);
   end

   // Monitor: sample transfers at the rising edge.
   always @(posedge clock) begin
      frac_pair_type p;
      frac_sum_type  want;
      int            bad;
      bad = 0;
      req_taken <= !reset && req.valid && req.ready;
      if (!reset && req.valid && req.ready) begin
         p = make_pair(req.first_numerator, req.first_denominator,
                       req.second_numerator, req.second_denominator);
         want = reduce_sum(p);
         if (want.num == 0)
            zero_sums <= zero_sums + 1;
         if (p.d1 == p.d2)
            equal_dens <= equal_dens + 1;
         expected_sums.push_back(want);
         transfers_in <= transfers_in + 1;
      end
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_sums.size() == 0) begin
            $display("%0t: unexpected sum %0d/%0d", $time,
                     rsp.sum_numerator, rsp.sum_denominator);
            bad = bad + 1;
         end else begin
            want = expected_sums.pop_front();
            if (rsp.sum_numerator !== want.num) begin
               $display("%0t: numerator expected %0d actual %0d", $time,
                        want.num, rsp.sum_numerator);
               bad = bad + 1;
            end
            if (rsp.sum_denominator !== want.den) begin
               $display("%0t: denominator expected %0d actual %0d", $time,
                        want.den, rsp.sum_denominator);
               bad = bad + 1;
            end
            sums_checked <= sums_checked + 1;
         end
      end
      if (bad != 0)
         errors <= errors + bad;
   end

   // Run control: timeout watch and end of test.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("fraction_add_reduce: mismatch");
         $finish;
      end
   end

   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);
      while (pending_pairs.size() != 0 || req.valid) @(posedge clock);
      while (expected_sums.size() != 0) @(posedge clock);
      repeat (1600) @(posedge clock);
      $display("checked %0d reduced sums (%0d zero, %0d shared denominators)",
               sums_checked, zero_sums, equal_dens);
      $display("%0d pairs sent, with random idling, stalls and one full drain",
               transfers_in);
      if (errors == 0 && expected_sums.size() == 0)
         $display("fraction_add_reduce: match");
      else
         $display("fraction_add_reduce: mismatch");
      $finish;
   end

endmodule

### files.f
rtl/core/fadd_pkg.sv
rtl/core/fadd_if.sv
rtl/core/fadd_cell.sv
rtl/core/fadd_div.sv
rtl/core/fraction_add_reduce.sv
tb/sv/tb_top.sv
